[sv/tmq_pkg.sv]
// Package for the multi-slot timer queue: field widths, command, kind and
// status codes, the slot table entry type and reset constants.
// No dependencies.
package tmq_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int MAX_SCAN      = 16;

   localparam int CMD_W     = 2;
   localparam int PERIOD_W  = 22;
   localparam int TASK_W    = 8;
   localparam int WINDOW_W  = 16;
   localparam int TIMER_W   = 4;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int NOW_W     = 32;
   localparam int TICK_MS_W = 10;

   localparam logic [TICK_MS_W-1:0] TICK_MS_RESET = 10'd100;

   localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEREGISTER = 2'd2;

   localparam logic [KIND_W-1:0] KIND_REGISTER   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEREGISTER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRY     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_REG = 2'd2;

   typedef struct packed {
      logic [NOW_W-1:0]    expiry;
      logic [PERIOD_W-1:0] period;
      logic                one_shot;
      logic [TASK_W-1:0]   owner_task;
      logic [WINDOW_W-1:0] owner_window;
   } slot_entry_type;

endpackage

[sv/tmq_slot_ram.sv]
// Slot table memory: one entry per timer slot, one write and one read port,
// registered read data. Depends on tmq_pkg.
module tmq_slot_ram #(
   parameter int DEPTH = tmq_pkg::SLOTS_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  tmq_pkg::slot_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output tmq_pkg::slot_entry_type rd_data
);

   tmq_pkg::slot_entry_type mem [DEPTH];
   tmq_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tmq_order_ram.sv]
// Order queue memory: circular list of slot numbers, one write and one read
// port, registered read data. No package dependency.
module tmq_order_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [AW-1:0] rd_data
);

   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/multi_slot_timer_queue_top.sv]
// Top level of the multi-slot timer queue: command sequencer, slot flags,
// queue pointers. Depends on tmq_pkg, tmq_slot_ram and tmq_order_ram.
//
//   channel   ports              transfer
//   -------   -----------------  ------------------------------------------
//   request   start, req_*       start high and busy low at a clock edge
//   result    rsp_valid, rsp_*   rsp_valid high for one cycle, always taken
//   control   csr_write_*        csr_write_en high at a clock edge
//
// Every command first passes a decode state. Register then walks the
// slot flags, one slot per cycle, from slot 0 to the first free one.
// Deregister walks the order queue entry by entry (memory read, then
// compare and shift down). A tick takes each expired timer through a queue
// read, a slot table read, and a pop with re-arm, or release if one-shot;
// it stops when the scan bound is reached or the queue is empty, or on a
// head that is not yet due. Both memories have registered read data.
// Reset is synchronous and clears control state only; memory contents are
// meaningless until written. The receiver cannot stall; each expiry is held
// until the next one is popped or the tick ends, so that the final one
// carries rsp_last.
module multi_slot_timer_queue_top #(
   parameter int NUM_SLOTS = tmq_pkg::SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tmq_pkg::CMD_W-1:0]      req_command,
   input  logic [tmq_pkg::PERIOD_W-1:0]   req_period_ms,
   input  logic                           req_one_shot,
   input  logic [tmq_pkg::TASK_W-1:0]     req_task_id,
   input  logic [tmq_pkg::WINDOW_W-1:0]   req_window_id,
   input  logic [tmq_pkg::TIMER_W-1:0]    req_timer_id,
   output logic                           rsp_valid,
   output logic [tmq_pkg::KIND_W-1:0]     rsp_kind,
   output logic [tmq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tmq_pkg::TIMER_W-1:0]    rsp_slot_id,
   output logic [tmq_pkg::TASK_W-1:0]     rsp_notify_task,
   output logic [tmq_pkg::WINDOW_W-1:0]   rsp_notify_window,
   output logic                           rsp_last,
   input  logic                           csr_write_en,
   input  logic [tmq_pkg::TICK_MS_W-1:0]  csr_write_data
);

   localparam int SW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REG_FIND,
      ST_DREG_RD,
      ST_DREG_CHK,
      ST_TICK_RD,
      ST_TICK_Q,
      ST_TICK_S
   } state_type;

   // Add an offset to a queue position and wrap once around the depth.
   function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] base,
                                              input logic [CW-1:0] offs);
      logic [CW:0] sum;
      begin
         sum = (CW+1)'(base) + (CW+1)'(offs);
         if (sum >= (CW+1)'(NUM_SLOTS)) begin
            sum = sum - (CW+1)'(NUM_SLOTS);
         end
         wrap_add = sum[SW-1:0];
      end
   endfunction

   state_type                          state_ff, state_in;
   logic [tmq_pkg::TICK_MS_W-1:0]      tick_ms_ff, tick_ms_in;
   logic [tmq_pkg::NOW_W-1:0]          now_ff, now_in;
   logic [SW-1:0]                      head_ff, head_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [NUM_SLOTS-1:0]               used_ff, used_in;

   logic [tmq_pkg::CMD_W-1:0]          cmd_ff, cmd_in;
   logic [tmq_pkg::PERIOD_W-1:0]       period_ff, period_in;
   logic                               one_shot_ff, one_shot_in;
   logic [tmq_pkg::TASK_W-1:0]         task_ff, task_in;
   logic [tmq_pkg::WINDOW_W-1:0]       window_ff, window_in;
   logic [tmq_pkg::TIMER_W-1:0]        tid_ff, tid_in;

   logic [CW-1:0]                      idx_ff, idx_in;
   logic [CW-1:0]                      scan_ff, scan_in;
   logic [CW-1:0]                      popped_ff, popped_in;
   logic                               found_ff, found_in;
   logic [SW-1:0]                      slot_ff, slot_in;

   logic                               pend_valid_ff, pend_valid_in;
   logic [SW-1:0]                      pend_slot_ff, pend_slot_in;
   logic [tmq_pkg::TASK_W-1:0]         pend_task_ff, pend_task_in;
   logic [tmq_pkg::WINDOW_W-1:0]       pend_window_ff, pend_window_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [tmq_pkg::KIND_W-1:0]         rsp_kind_ff, rsp_kind_in;
   logic [tmq_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [tmq_pkg::TIMER_W-1:0]        rsp_slot_ff, rsp_slot_in;
   logic [tmq_pkg::TASK_W-1:0]         rsp_task_ff, rsp_task_in;
   logic [tmq_pkg::WINDOW_W-1:0]       rsp_window_ff, rsp_window_in;
   logic                               rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                               q_we;
   logic [SW-1:0]                      q_wr_addr, q_wr_data, q_rd_addr, q_rd_data;
   logic                               s_we;
   logic [SW-1:0]                      s_wr_addr, s_rd_addr;
   tmq_pkg::slot_entry_type            s_wr_data, s_rd_data;

   logic [SW-1:0]                      find_slot;
   logic [SW-1:0]                      tid_slot;
   logic                               tid_bad;
   logic [tmq_pkg::NOW_W-1:0]          age;

   tmq_order_ram #(.DEPTH(NUM_SLOTS), .AW(SW)) u_order_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wr_addr),
      .wr_data (q_wr_data),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   tmq_slot_ram #(.DEPTH(NUM_SLOTS), .AW(SW)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_wr_addr),
      .wr_data (s_wr_data),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   assign find_slot = idx_ff[SW-1:0];
   assign tid_slot  = SW'(tid_ff);
   assign tid_bad   = (32'(tid_ff) >= 32'(NUM_SLOTS)) || !used_ff[tid_slot];
   // Wrapping age of the head timer; expired while the top bit is clear.
   assign age       = now_ff - s_rd_data.expiry;

   always_comb begin
      state_in       = state_ff;
      tick_ms_in     = csr_write_en ? csr_write_data : tick_ms_ff;
      now_in         = now_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      used_in        = used_ff;
      cmd_in         = cmd_ff;
      period_in      = period_ff;
      one_shot_in    = one_shot_ff;
      task_in        = task_ff;
      window_in      = window_ff;
      tid_in         = tid_ff;
      idx_in         = idx_ff;
      scan_in        = scan_ff;
      popped_in      = popped_ff;
      found_in       = found_ff;
      slot_in        = slot_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_task_in   = pend_task_ff;
      pend_window_in = pend_window_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_task_in    = rsp_task_ff;
      rsp_window_in  = rsp_window_ff;
      rsp_last_in    = rsp_last_ff;

      q_we      = 1'b0;
      q_wr_addr = wrap_add(head_ff, count_ff);
      q_wr_data = find_slot;
      q_rd_addr = head_ff;
      s_we      = 1'b0;
      s_wr_addr = find_slot;
      s_wr_data = s_rd_data;
      s_rd_addr = q_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in      = req_command;
               period_in   = req_period_ms;
               one_shot_in = req_one_shot;
               task_in     = req_task_id;
               window_in   = req_window_id;
               tid_in      = req_timer_id;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            idx_in   = '0;
            found_in = 1'b0;
            case (cmd_ff)
               tmq_pkg::CMD_REGISTER: begin
                  if (count_ff == CW'(NUM_SLOTS)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = tmq_pkg::KIND_REGISTER;
                     rsp_status_in = tmq_pkg::STATUS_FULL;
                     rsp_slot_in   = '0;
                     rsp_task_in   = '0;
                     rsp_window_in = '0;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     state_in = ST_REG_FIND;
                  end
               end
               tmq_pkg::CMD_DEREGISTER: begin
                  if (tid_bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = tmq_pkg::KIND_DEREGISTER;
                     rsp_status_in = tmq_pkg::STATUS_NOT_REG;
                     rsp_slot_in   = tid_ff;
                     rsp_task_in   = '0;
                     rsp_window_in = '0;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     state_in = ST_DREG_RD;
                  end
               end
               tmq_pkg::CMD_TICK: begin
                  now_in        = now_ff + tmq_pkg::NOW_W'(tick_ms_ff);
                  // Bound the scan by the queue length at the start of the tick, capped at MAX_SCAN.
                  scan_in       = (32'(count_ff) > tmq_pkg::MAX_SCAN)
                                  ? CW'(tmq_pkg::MAX_SCAN) : count_ff;
                  popped_in     = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_TICK_RD;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_REG_FIND: begin
            if (!used_ff[find_slot]) begin
               s_we                   = 1'b1;
               s_wr_addr              = find_slot;
               s_wr_data.expiry       = now_ff + tmq_pkg::NOW_W'(period_ff);
               s_wr_data.period       = period_ff;
               s_wr_data.one_shot     = one_shot_ff;
               s_wr_data.owner_task   = task_ff;
               s_wr_data.owner_window = window_ff;
               q_we                   = 1'b1;
               q_wr_addr              = wrap_add(head_ff, count_ff);
               q_wr_data              = find_slot;
               count_in               = count_ff + CW'(1);
               used_in[find_slot]     = 1'b1;
               rsp_valid_in           = 1'b1;
               rsp_kind_in            = tmq_pkg::KIND_REGISTER;
               rsp_status_in          = tmq_pkg::STATUS_OK;
               rsp_slot_in            = tmq_pkg::TIMER_W'(find_slot);
               rsp_task_in            = '0;
               rsp_window_in          = '0;
               rsp_last_in            = 1'b1;
               state_in               = ST_IDLE;
            end else if (find_slot == SW'(NUM_SLOTS - 1)) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = tmq_pkg::KIND_REGISTER;
               rsp_status_in = tmq_pkg::STATUS_FULL;
               rsp_slot_in   = '0;
               rsp_task_in   = '0;
               rsp_window_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         ST_DREG_RD: begin
            if (idx_ff == count_ff) begin
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
               end
               used_in[tid_slot] = 1'b0;
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = tmq_pkg::KIND_DEREGISTER;
               rsp_status_in     = tmq_pkg::STATUS_OK;
               rsp_slot_in       = tid_ff;
               rsp_task_in       = '0;
               rsp_window_in     = '0;
               rsp_last_in       = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               q_rd_addr = wrap_add(head_ff, idx_ff);
               state_in  = ST_DREG_CHK;
            end
         end

         ST_DREG_CHK: begin
            // Past the removed entry, shift each one down by a place.
            if (found_ff) begin
               q_we      = 1'b1;
               q_wr_addr = wrap_add(head_ff, idx_ff - CW'(1));
               q_wr_data = q_rd_data;
            end else if (32'(q_rd_data) == 32'(tid_ff)) begin
               found_in = 1'b1;
            end
            idx_in   = idx_ff + CW'(1);
            state_in = ST_DREG_RD;
         end

         ST_TICK_RD: begin
            if (popped_ff == scan_ff || count_ff == '0) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = tmq_pkg::KIND_EXPIRY;
                  rsp_status_in = tmq_pkg::STATUS_OK;
                  rsp_slot_in   = tmq_pkg::TIMER_W'(pend_slot_ff);
                  rsp_task_in   = pend_task_ff;
                  rsp_window_in = pend_window_ff;
                  rsp_last_in   = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               q_rd_addr = head_ff;
               state_in  = ST_TICK_Q;
            end
         end

         ST_TICK_Q: begin
            s_rd_addr = q_rd_data;
            slot_in   = q_rd_data;
            state_in  = ST_TICK_S;
         end

         ST_TICK_S: begin
            if (age[tmq_pkg::NOW_W-1]) begin
               // Head not yet due: stop and flush the held expiry as last.
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = tmq_pkg::KIND_EXPIRY;
                  rsp_status_in = tmq_pkg::STATUS_OK;
                  rsp_slot_in   = tmq_pkg::TIMER_W'(pend_slot_ff);
                  rsp_task_in   = pend_task_ff;
                  rsp_window_in = pend_window_ff;
                  rsp_last_in   = 1'b1;
               end
               state_in = ST_IDLE;
            end else begin
               head_in = wrap_add(head_ff, CW'(1));
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = tmq_pkg::KIND_EXPIRY;
                  rsp_status_in = tmq_pkg::STATUS_OK;
                  rsp_slot_in   = tmq_pkg::TIMER_W'(pend_slot_ff);
                  rsp_task_in   = pend_task_ff;
                  rsp_window_in = pend_window_ff;
                  rsp_last_in   = 1'b0;
               end
               pend_valid_in  = 1'b1;
               pend_slot_in   = slot_ff;
               pend_task_in   = s_rd_data.owner_task;
               pend_window_in = s_rd_data.owner_window;
               popped_in      = popped_ff + CW'(1);
               if (!s_rd_data.one_shot) begin
                  // Re-arm and append at the tail; queue length is unchanged.
                  s_we             = 1'b1;
                  s_wr_addr        = slot_ff;
                  s_wr_data        = s_rd_data;
                  s_wr_data.expiry = now_ff + tmq_pkg::NOW_W'(s_rd_data.period);
                  q_we             = 1'b1;
                  q_wr_addr        = wrap_add(head_ff, count_ff);
                  q_wr_data        = slot_ff;
               end else begin
                  count_in         = count_ff - CW'(1);
                  used_in[slot_ff] = 1'b0;
               end
               state_in = ST_TICK_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ms_ff    <= tmq_pkg::TICK_MS_RESET;
         now_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         used_ff       <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ms_ff    <= tick_ms_in;
         now_ff        <= now_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         used_ff       <= used_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      period_ff      <= period_in;
      one_shot_ff    <= one_shot_in;
      task_ff        <= task_in;
      window_ff      <= window_in;
      tid_ff         <= tid_in;
      idx_ff         <= idx_in;
      scan_ff        <= scan_in;
      popped_ff      <= popped_in;
      slot_ff        <= slot_in;
      pend_slot_ff   <= pend_slot_in;
      pend_task_ff   <= pend_task_in;
      pend_window_ff <= pend_window_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_task_ff    <= rsp_task_in;
      rsp_window_ff  <= rsp_window_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot_id       = rsp_slot_ff;
   assign rsp_notify_task   = rsp_task_ff;
   assign rsp_notify_window = rsp_window_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

[sv/tmq_checker.sv]
// Port-level checks for the timer queue, bound to the top level.
// Depends on tmq_pkg and multi_slot_timer_queue_top.
module tmq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [tmq_pkg::KIND_W-1:0]     rsp_kind,
   input logic [tmq_pkg::TASK_W-1:0]     rsp_notify_task,
   input logic [tmq_pkg::WINDOW_W-1:0]   rsp_notify_window,
   input logic                           rsp_last
);

   // A result only comes out of a command that was in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a command in progress");

   // The final result frees the block; earlier ones keep it busy.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == !busy))
      else $error("busy does not match last flag");

   // Replies are single results.
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != tmq_pkg::KIND_EXPIRY) |-> rsp_last)
      else $error("reply not marked last");

   a_reply_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != tmq_pkg::KIND_EXPIRY)
         |-> (rsp_notify_task == '0 && rsp_notify_window == '0))
      else $error("reply carries notify data");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not set busy");

endmodule

bind multi_slot_timer_queue_top tmq_checker u_tmq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_kind          (rsp_kind),
   .rsp_notify_task   (rsp_notify_task),
   .rsp_notify_window (rsp_notify_window),
   .rsp_last          (rsp_last)
);
